// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/rtyr_pkg.sv =====
// ----------------------------------------------------------------------------
// rtyr_pkg
// Types and constants of the RGBA tile to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rtyr_pkg;

    localparam int PIX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int LANES      = 4;
    localparam int SUM_W      = 10;
    localparam int LUMA_ACC_W = 16;
    localparam int CHR_ACC_W  = 21;
    localparam int TILE_REG_W = 12;
    localparam int DEST_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_CNT_MAX = (1 << TILE_REG_W) - 1;

    localparam int IN_TDATA_W  = LANES * PIX_W;
    localparam int OUT_TDATA_W = 72;

    localparam logic [LUMA_ACC_W-1:0] Y_KR = 16'd55;
    localparam logic [LUMA_ACC_W-1:0] Y_KG = 16'd183;
    localparam logic [LUMA_ACC_W-1:0] Y_KB = 16'd19;

    localparam logic [CHR_ACC_W-1:0] CB_KR  = 21'd29;
    localparam logic [CHR_ACC_W-1:0] CB_KG  = 21'd99;
    localparam logic [CHR_ACC_W-1:0] CB_KB  = 21'd128;
    localparam logic [CHR_ACC_W-1:0] CR_KR  = 21'd128;
    localparam logic [CHR_ACC_W-1:0] CR_KG  = 21'd116;
    localparam logic [CHR_ACC_W-1:0] CR_KB  = 21'd12;
    localparam logic [CHR_ACC_W-1:0] CHR_OFFSET = 21'd131584;
    localparam logic [BYTE_W-1:0]    CHR_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_LANE     = 3'd0,
        REG_GREEN_LANE   = 3'd1,
        REG_BLUE_LANE    = 3'd2,
        REG_ROTATION     = 3'd3,
        REG_TILE_COLUMNS = 3'd4,
        REG_TILE_ROWS    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] red;
        logic [1:0] green;
        logic [1:0] blue;
    } lane_sel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] y;
    } pix_t;

    typedef struct packed {
        logic [DEST_W-1:0] col;
        logic [DEST_W-1:0] row;
        logic              frame_end;
    } dest_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tl;
        logic [BYTE_W-1:0] tr;
        logic [BYTE_W-1:0] bl;
        logic [BYTE_W-1:0] br;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
    } yuv_t;

endpackage

// ===== src/rgba_tile_to_yuv420_rotate.sv =====
// An accepted beat passes the four parallel lane registers, then the merge
// stage, which sums the lanes, then forms chroma, in two further registered
// stages, to m_tvalid. Throughput: one 2x2 tile per cycle while m_tready holds.
// Reset: aresetn (synchronous, active low) empties the pipeline, zeroes the tile
// counter and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// rgba_tile_to_yuv420_rotate
// 2x2 RGBA tile to YUV 4:2:0 with BT.709 full range and tile rotation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgba_tile_to_yuv420_rotate #(
    parameter int MAX_TILES_PER_SIDE = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg_data: register value; lane and rotation registers use its low two bits
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rtyr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtyr_pkg::TILE_REG_W-1:0]    cfg_data,
    // s_tdata: pix_r0c0, pix_r0c1, pix_r1c0, pix_r1c1
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rtyr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: y_top_left, y_top_right, y_bottom_left, y_bottom_right,
    //          cb_value, cr_value, dest_tile_col, dest_tile_row, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rtyr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import rtyr_pkg::*;

    lane_sel_t             lane_sel_reg;
    rot_t                  rot_reg;
    logic [TILE_REG_W-1:0] cols_reg, rows_reg;

    logic      v1_reg, v2_reg, v3_reg;
    logic      en1, en2, en3, accept, wrap;
    dest_t     dest, dest1_reg, dest2_reg, dest3_reg;
    pix_t [3:0] lanes;
    yuv_t      yuv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_sel_reg.red   <= 2'd0;
            lane_sel_reg.green <= 2'd1;
            lane_sel_reg.blue  <= 2'd2;
            rot_reg            <= ROT_0;
            cols_reg           <= TILE_REG_W'(1);
            rows_reg           <= TILE_REG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_RED_LANE:     lane_sel_reg.red   <= cfg_data[1:0];
                REG_GREEN_LANE:   lane_sel_reg.green <= cfg_data[1:0];
                REG_BLUE_LANE:    lane_sel_reg.blue  <= cfg_data[1:0];
                REG_ROTATION:     rot_reg            <= rot_t'(cfg_data[1:0]);
                REG_TILE_COLUMNS: cols_reg           <= cfg_data;
                REG_TILE_ROWS:    rows_reg           <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance each stage when it is empty or its successor moves
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    rtyr_tile_ctr #(
        .MAX_TILES_PER_SIDE(MAX_TILES_PER_SIDE)
    ) u_tile_ctr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .rotation     (rot_reg),
        .tile_columns (cols_reg),
        .tile_rows    (rows_reg),
        .dest         (dest),
        .wrap         (wrap)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        rtyr_lane u_lane (
            .aclk    (aclk),
            .load    (accept),
            .pixel   (s_tdata[k*PIX_W +: PIX_W]),
            .sel     (lane_sel_reg),
            .pix_reg (lanes[k])
        );
    end

    rtyr_merge u_merge (
        .aclk     (aclk),
        .load_sum (en2 && v1_reg),
        .load_out (en3 && v2_reg),
        .rotation (rot_reg),
        .lanes    (lanes),
        .yuv_reg  (yuv)
    );

    always_ff @(posedge aclk) begin
        if (accept)          dest1_reg <= dest;
        if (en2 && v1_reg)   dest2_reg <= dest1_reg;
        if (en3 && v2_reg)   dest3_reg <= dest2_reg;
    end

    assign m_tvalid = v3_reg;
    assign m_tlast  = dest3_reg.frame_end;
    assign m_tdata  = {2'b00, dest3_reg.row, dest3_reg.col,
                       yuv.cr, yuv.cb, yuv.br, yuv.bl, yuv.tr, yuv.tl};

    `ASSERT_IMP(a_stall_full, aclk, aresetn, !s_tready, v1_reg && v2_reg && v3_reg && !m_tready)
    `ASSERT_NXT(a_wrap_zero, aclk, aresetn, accept && wrap,
                (u_tile_ctr.col_reg == '0) && (u_tile_ctr.row_reg == '0))
    `ASSERT_NXT(a_last_follows, aclk, aresetn, v2_reg && en3 && dest2_reg.frame_end,
                m_tvalid && m_tlast)

endmodule

// ===== src/rtyr_lane.sv =====
// ----------------------------------------------------------------------------
// rtyr_lane
// One pixel lane: colour byte selection and luma, registered.
// ----------------------------------------------------------------------------
module rtyr_lane (
    input  logic                      aclk,
    input  logic                      load,
    input  logic [rtyr_pkg::PIX_W-1:0] pixel,
    input  rtyr_pkg::lane_sel_t       sel,
    output rtyr_pkg::pix_t            pix_reg
);
    import rtyr_pkg::*;

    logic [BYTE_W-1:0]     r, g, b;
    logic [LUMA_ACC_W-1:0] y_acc;
    pix_t                  pix_next;

    assign r = BYTE_W'(pixel >> {sel.red,   3'b000});
    assign g = BYTE_W'(pixel >> {sel.green, 3'b000});
    assign b = BYTE_W'(pixel >> {sel.blue,  3'b000});

    assign y_acc = LUMA_ACC_W'(r) * Y_KR + LUMA_ACC_W'(g) * Y_KG + LUMA_ACC_W'(b) * Y_KB;

    always_comb begin
        pix_next.r = r;
        pix_next.g = g;
        pix_next.b = b;
        pix_next.y = y_acc[LUMA_ACC_W-1:LUMA_ACC_W-BYTE_W];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= pix_next;
        end
    end

endmodule

// ===== src/rtyr_merge.sv =====
// ----------------------------------------------------------------------------
// rtyr_merge
// Merge of the four lanes: colour sums and luma placement, then chroma.
// ----------------------------------------------------------------------------
module rtyr_merge (
    input  logic                   aclk,
    input  logic                   load_sum,
    input  logic                   load_out,
    input  rtyr_pkg::rot_t         rotation,
    input  rtyr_pkg::pix_t [3:0]   lanes,
    output rtyr_pkg::yuv_t         yuv_reg
);
    import rtyr_pkg::*;

    logic [SUM_W-1:0]     sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]     sum_r_next, sum_g_next, sum_b_next;
    logic [BYTE_W-1:0]    tl_reg, tr_reg, bl_reg, br_reg;
    logic [BYTE_W-1:0]    tl_next, tr_next, bl_next, br_next;
    logic [CHR_ACC_W-1:0] cb_acc, cr_acc;
    logic [BYTE_W-1:0]    cb_sat, cr_sat;
    yuv_t                 yuv_next;

    function automatic logic [BYTE_W-1:0] chr_clamp(input logic [CHR_ACC_W-1:0] acc);
        logic [CHR_ACC_W-11:0] q;
        q = acc[CHR_ACC_W-1:10];
        if (q[CHR_ACC_W-11]) begin
            return '0;
        end else if (|q[CHR_ACC_W-12:BYTE_W]) begin
            return CHR_MAX;
        end else begin
            return q[BYTE_W-1:0];
        end
    endfunction

    assign sum_r_next = SUM_W'(lanes[0].r) + SUM_W'(lanes[1].r)
                      + SUM_W'(lanes[2].r) + SUM_W'(lanes[3].r);
    assign sum_g_next = SUM_W'(lanes[0].g) + SUM_W'(lanes[1].g)
                      + SUM_W'(lanes[2].g) + SUM_W'(lanes[3].g);
    assign sum_b_next = SUM_W'(lanes[0].b) + SUM_W'(lanes[1].b)
                      + SUM_W'(lanes[2].b) + SUM_W'(lanes[3].b);

    always_comb begin
        case (rotation)
            ROT_90: begin
                tl_next = lanes[2].y; tr_next = lanes[0].y;
                bl_next = lanes[3].y; br_next = lanes[1].y;
            end
            ROT_180: begin
                tl_next = lanes[3].y; tr_next = lanes[2].y;
                bl_next = lanes[1].y; br_next = lanes[0].y;
            end
            ROT_270: begin
                tl_next = lanes[1].y; tr_next = lanes[3].y;
                bl_next = lanes[0].y; br_next = lanes[2].y;
            end
            default: begin
                tl_next = lanes[0].y; tr_next = lanes[1].y;
                bl_next = lanes[2].y; br_next = lanes[3].y;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            tl_reg    <= tl_next;
            tr_reg    <= tr_next;
            bl_reg    <= bl_next;
            br_reg    <= br_next;
        end
    end

    assign cb_acc = CHR_OFFSET + CHR_ACC_W'(sum_b_reg) * CB_KB
                  - CHR_ACC_W'(sum_r_reg) * CB_KR - CHR_ACC_W'(sum_g_reg) * CB_KG;
    assign cr_acc = CHR_OFFSET + CHR_ACC_W'(sum_r_reg) * CR_KR
                  - CHR_ACC_W'(sum_g_reg) * CR_KG - CHR_ACC_W'(sum_b_reg) * CR_KB;

    assign cb_sat = chr_clamp(cb_acc);
    assign cr_sat = chr_clamp(cr_acc);

    always_comb begin
        yuv_next.tl = tl_reg;
        yuv_next.tr = tr_reg;
        yuv_next.bl = bl_reg;
        yuv_next.br = br_reg;
        yuv_next.cb = cb_sat;
        yuv_next.cr = cr_sat;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            yuv_reg <= yuv_next;
        end
    end

endmodule

// ===== src/rtyr_tile_ctr.sv =====
// ----------------------------------------------------------------------------
// rtyr_tile_ctr
// Source tile counter and destination tile position after rotation.
// ----------------------------------------------------------------------------
module rtyr_tile_ctr #(
    parameter int MAX_TILES_PER_SIDE = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  rtyr_pkg::rot_t                    rotation,
    input  logic [rtyr_pkg::TILE_REG_W-1:0]   tile_columns,
    input  logic [rtyr_pkg::TILE_REG_W-1:0]   tile_rows,
    output rtyr_pkg::dest_t                   dest,
    output logic                              wrap
);
    import rtyr_pkg::*;

    localparam int LIM = (MAX_TILES_PER_SIDE < CFG_CNT_MAX) ? MAX_TILES_PER_SIDE : CFG_CNT_MAX;
    localparam int CW  = (LIM > 1) ? $clog2(LIM) : 1;

    logic [CW-1:0] col_reg, row_reg, col_next, row_next;
    logic [CW-1:0] cols_m1, rows_m1, c, r, dc, dr;
    logic          last_col, last_row;

    function automatic logic [CW-1:0] last_index(input logic [TILE_REG_W-1:0] cnt);
        if (cnt == '0) begin
            return '0;
        end else if (32'(cnt) > LIM) begin
            return CW'(LIM - 1);
        end else begin
            return CW'(cnt - 1'b1);
        end
    endfunction

    assign cols_m1 = last_index(tile_columns);
    assign rows_m1 = last_index(tile_rows);

    assign c = (col_reg < cols_m1) ? col_reg : cols_m1;
    assign r = (row_reg < rows_m1) ? row_reg : rows_m1;

    assign last_col = (c == cols_m1);
    assign last_row = (r == rows_m1);
    assign wrap     = last_col && last_row;

    always_comb begin
        case (rotation)
            ROT_90: begin
                dc = rows_m1 - r; dr = c;
            end
            ROT_180: begin
                dc = cols_m1 - c; dr = rows_m1 - r;
            end
            ROT_270: begin
                dc = r; dr = cols_m1 - c;
            end
            default: begin
                dc = c; dr = r;
            end
        endcase
    end

    always_comb begin
        dest.col       = DEST_W'(dc);
        dest.row       = DEST_W'(dr);
        dest.frame_end = wrap;
    end

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : r + 1'b1;
        end else begin
            col_next = c + 1'b1;
            row_next = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== test/rgba_tile_to_yuv420_rotate_test.sv =====
// ----------------------------------------------------------------------------
// rgba_tile_to_yuv420_rotate_test
// Self-checking bench for the tile colour converter: a directed script of
// extreme colours, lane swaps, every rotation and odd tile counts, then
// random tiles under changing settings and back-pressure. Every output beat
// is compared field by field against the script's fixed values where it gives
// them, else against a behavioural model of the converter and its tile counter.
// ----------------------------------------------------------------------------
module rgba_tile_to_yuv420_rotate_test;

    import rtyr_pkg::*;

    localparam int SCRIPT_LEN   = 37;
    localparam int RANDOM_ITEMS = 530;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PRINT_MAX    = 40;

    typedef struct packed {
        logic [OUT_TDATA_W-1:0] data;
        logic                   last;
    } yuv_beat_t;

    typedef struct packed {
        logic                  is_write;
        reg_idx_t              idx;
        logic [TILE_REG_W-1:0] value;
        logic [IN_TDATA_W-1:0] tile;
        logic                  known;
        logic [7:0]            y;
        logic [7:0]            cb;
        logic [7:0]            cr;
        logic [DEST_W-1:0]     dc;
        logic [DEST_W-1:0]     dr;
        logic                  last;
    } script_row_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TILE_REG_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // configuration and tile counter as the converter should hold them
    logic [1:0]            lane_r, lane_g, lane_b;
    rot_t                  rot_sel;
    logic [TILE_REG_W-1:0] cols_reg, rows_reg;
    int                    tile_col, tile_row;

    yuv_beat_t yuv_due[$];
    int        mismatches   = 0;
    int        beats_out    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_request = 1'b0;
    logic      hold_active  = 1'b0;

    script_row_t script [0:SCRIPT_LEN-1] = '{
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h00000000}}, 1'b1,
          8'd0, 8'd128, 8'd128, 11'd0, 11'd0, 1'b1},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'hFFFFFFFF}}, 1'b1,
          8'd255, 8'd128, 8'd128, 11'd0, 11'd0, 1'b1},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h00FF0000}}, 1'b1,
          8'd18, 8'd255, 8'd116, 11'd0, 11'd0, 1'b1},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h000000FF}}, 1'b1,
          8'd54, 8'd99, 8'd255, 11'd0, 11'd0, 1'b1},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h0000FFFF}}, 1'b1,
          8'd237, 8'd1, 8'd140, 11'd0, 11'd0, 1'b1},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h0000FF00}}, 1'b1,
          8'd182, 8'd29, 8'd12, 11'd0, 11'd0, 1'b1},
        '{1'b1, REG_RED_LANE, 12'hFFD, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_GREEN_LANE, 12'hFFB, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_BLUE_LANE, 12'h000, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h12345678_9ABCDEF0_FF00FF00_00FFFF00, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_RED_LANE, 12'h000, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_GREEN_LANE, 12'h001, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_BLUE_LANE, 12'h002, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_COLUMNS, 12'h000, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_ROWS, 12'hFFF, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'hFF102030_40FF5060_7080FF90_A0B0C0FF, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h01020304_FEFDFCFB_80808080_7F7F7F7F, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_COLUMNS, 12'h003, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_ROWS, 12'h002, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_ROTATION, {10'd0, ROT_90}, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h000000FF_0000FF00_00FF0000_FF000000, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'hDEADBEEF_CAFEF00D_0BADC0DE_FEEDFACE, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h11111111_22222222_44444444_88888888, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_ROTATION, {10'd0, ROT_180}, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h00FFFFFF_FF00FFFF_FFFF00FF_FFFFFF00, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h55AA55AA_AA55AA55_33CC33CC_CC33CC33, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_ROTATION, {10'd0, ROT_270}, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h0F0F0F0F_F0F0F0F0_00FF00FF_FF00FF00, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h89ABCDEF_01234567_76543210_FEDCBA98, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_COLUMNS, 12'h800, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_ROWS, 12'h800, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_ROTATION, {10'd0, ROT_0}, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h10203040_50607080_90A0B0C0_D0E0F000, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, 128'h0000007F_00007F00_007F0000_7F000000, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_COLUMNS, 12'h001, 128'd0, 1'b0,
          8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b1, REG_TILE_ROWS, 12'h001, 128'd0, 1'b0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0},
        '{1'b0, REG_RED_LANE, 12'h000, {4{32'h00000000}}, 1'b1,
          8'd0, 8'd128, 8'd128, 11'd0, 11'd0, 1'b1}
    };

    rgba_tile_to_yuv420_rotate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int clamp_count(input logic [TILE_REG_W-1:0] value);
        if (value == 0) return 1;
        if (value > 2048) return 2048;
        return int'(value);
    endfunction

    // work out one output beat and advance the tile counter
    function automatic yuv_beat_t convert_tile(input logic [IN_TDATA_W-1:0] tile);
        yuv_beat_t  beat;
        logic [31:0] p;
        int         y [4];
        int         red, green, blue;
        int         sr, sg, sb, cb, cr;
        int         cols, rows, c, r, dc, dr;
        int         tl, tr, bl, br;
        logic       last_col, last_row;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int k = 0; k < 4; k++) begin
            p     = tile[32*k +: 32];
            red   = int'(p[8*lane_r +: 8]);
            green = int'(p[8*lane_g +: 8]);
            blue  = int'(p[8*lane_b +: 8]);
            y[k]  = (55 * red + 183 * green + 19 * blue) >>> 8;
            sr += red;
            sg += green;
            sb += blue;
        end
        cb = (-29 * sr - 99 * sg + 128 * sb + 131584) >>> 10;
        cr = (128 * sr - 116 * sg - 12 * sb + 131584) >>> 10;
        if (cb > 255) cb = 255;
        if (cr > 255) cr = 255;
        if (cb < 0) cb = 0;
        if (cr < 0) cr = 0;
        cols = clamp_count(cols_reg);
        rows = clamp_count(rows_reg);
        c = (tile_col < cols - 1) ? tile_col : cols - 1;
        r = (tile_row < rows - 1) ? tile_row : rows - 1;
        last_col = (c == cols - 1);
        last_row = (r == rows - 1);
        case (rot_sel)
            ROT_90: begin
                tl = y[2]; tr = y[0]; bl = y[3]; br = y[1];
                dc = rows - 1 - r; dr = c;
            end
            ROT_180: begin
                tl = y[3]; tr = y[2]; bl = y[1]; br = y[0];
                dc = cols - 1 - c; dr = rows - 1 - r;
            end
            ROT_270: begin
                tl = y[1]; tr = y[3]; bl = y[0]; br = y[2];
                dc = r; dr = cols - 1 - c;
            end
            default: begin
                tl = y[0]; tr = y[1]; bl = y[2]; br = y[3];
                dc = c; dr = r;
            end
        endcase
        beat.data = {2'b00, 11'(dr), 11'(dc), 8'(cr), 8'(cb), 8'(br), 8'(bl), 8'(tr), 8'(tl)};
        beat.last = last_col && last_row;
        if (last_col) begin
            tile_col = 0;
            tile_row = last_row ? 0 : r + 1;
        end else begin
            tile_col = c + 1;
            tile_row = r;
        end
        return beat;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_tile();
        logic [IN_TDATA_W-1:0] tile;
        logic [31:0]           p;
        p = $urandom;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
                0, 1: p = $urandom;
                2: begin
                    for (int b = 0; b < 4; b++)
                        p[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default: ;
            endcase
            tile[32*k +: 32] = p;
        end
        return tile;
    endfunction

    function automatic logic [TILE_REG_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'h800;
            3: return 12'($urandom_range(2049, 4095));
            4: return 12'($urandom_range(6, 2047));
            default: return 12'($urandom_range(1, 5));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_MAX) $display("mismatch, output beat %0d: %s", beats_out, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [TILE_REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_RED_LANE:     lane_r   = value[1:0];
            REG_GREEN_LANE:   lane_g   = value[1:0];
            REG_BLUE_LANE:    lane_b   = value[1:0];
            REG_ROTATION:     rot_sel  = rot_t'(value[1:0]);
            REG_TILE_COLUMNS: cols_reg = value;
            REG_TILE_ROWS:    rows_reg = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_tile(input logic [IN_TDATA_W-1:0] tile, input logic known,
                             input yuv_beat_t typed);
        yuv_beat_t beat;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tile;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beat = convert_tile(tile);
        yuv_due.push_back(known ? typed : beat);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (yuv_due.size() != 0) @(posedge aclk);
    endtask

    // output side: ready with random stalls, compare each beat
    always @(posedge aclk) begin : yuv_monitor
        yuv_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (yuv_due.size() == 0) begin
                    report_mismatch("output beat with no tile pending");
                end else begin
                    want = yuv_due.pop_front();
                    check_field("y_top_left", int'(m_tdata[7:0]), int'(want.data[7:0]));
                    check_field("y_top_right", int'(m_tdata[15:8]), int'(want.data[15:8]));
                    check_field("y_bottom_left", int'(m_tdata[23:16]),
                                int'(want.data[23:16]));
                    check_field("y_bottom_right", int'(m_tdata[31:24]),
                                int'(want.data[31:24]));
                    check_field("cb_value", int'(m_tdata[39:32]), int'(want.data[39:32]));
                    check_field("cr_value", int'(m_tdata[47:40]), int'(want.data[47:40]));
                    check_field("dest_tile_col", int'(m_tdata[58:48]),
                                int'(want.data[58:48]));
                    check_field("dest_tile_row", int'(m_tdata[69:59]),
                                int'(want.data[69:59]));
                    check_field("pad", int'(m_tdata[71:70]), int'(want.data[71:70]));
                    check_field("frame_end", int'(m_tlast), int'(want.last));
                end
                beats_out++;
            end
        end
    end

    initial begin : receiver_hold
        wait (hold_request);
        @(posedge aclk);
        hold_active <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        yuv_beat_t typed;
        int        done;
        int        seg_len;
        lane_r   = 2'd0;
        lane_g   = 2'd1;
        lane_b   = 2'd2;
        rot_sel  = ROT_0;
        cols_reg = 12'd1;
        rows_reg = 12'd1;
        tile_col = 0;
        tile_row = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 47;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].is_write) begin
                drain();
                write_reg(script[i].idx, script[i].value);
            end else begin
                typed.data = {2'b00, script[i].dr, script[i].dc, script[i].cr, script[i].cb,
                              {4{script[i].y}}};
                typed.last = script[i].last;
                send_tile(script[i].tile, script[i].known, typed);
            end
        end

        typed = '0;
        done  = 0;
        while (done < RANDOM_ITEMS) begin
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 47;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            write_reg(REG_RED_LANE, 12'($urandom));
            write_reg(REG_GREEN_LANE, 12'($urandom));
            write_reg(REG_BLUE_LANE, 12'($urandom));
            write_reg(REG_ROTATION, 12'($urandom));
            write_reg(REG_TILE_COLUMNS, random_count());
            write_reg(REG_TILE_ROWS, random_count());
            if (send_idle_pct == 0) hold_request = 1'b1;
            seg_len = $urandom_range(8, 40);
            for (int n = 0; n < seg_len; n++) send_tile(random_tile(), 1'b0, typed);
            done += seg_len;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rtyr_pkg.sv
src/rtyr_lane.sv
src/rtyr_merge.sv
src/rtyr_tile_ctr.sv
src/rgba_tile_to_yuv420_rotate.sv
test/rgba_tile_to_yuv420_rotate_test.sv
